/* sv/kbeg_pkg.sv */
// ----------------------------------------------------------------------------
// kbeg_pkg: shared types and constants of the key bitmap event generator
// Request structs, configuration view, register indexes, scancode table.
// ----------------------------------------------------------------------------
package kbeg_pkg;

  localparam int KEY_BLOCKS_DEF = 8;
  localparam int BLOCK_BITS     = 32;
  localparam int BIT_W          = 5;
  localparam int TICK_W         = 32;
  localparam int INTERVAL_W     = 16;
  localparam logic [15:0] INTERVAL_RST = 16'd500;
  localparam logic [7:0]  EXT_LIMIT    = 8'h7F;

  typedef struct packed {
    logic [2:0]  block_index;
    logic [31:0] key_bits;
    logic [31:0] current_tick;
  } in_t;

  typedef struct packed {
    logic        key_down;
    logic [7:0]  key_code;
    logic [31:0] message_word;
    logic        last_event;
  } out_t;

  // configuration as seen by the event engine
  typedef struct packed {
    logic [INTERVAL_W-1:0] repeat_interval_ms;
    logic [255:0]          exclude;
  } cfg_t;

  typedef enum logic [2:0] {
    REG_INTERVAL = 3'd0,
    REG_EXCL_0   = 3'd1,
    REG_EXCL_1   = 3'd2,
    REG_EXCL_2   = 3'd3,
    REG_EXCL_3   = 3'd4
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_READ  = 4'b0010,
    S_EVAL  = 4'b0100,
    S_FLUSH = 4'b1000
  } state_t;

  localparam logic [7:0] CODE_TABLE [0:255] = '{
    8'h00,8'h1B,8'h31,8'h32,8'h33,8'h34,8'h35,8'h36,
    8'h37,8'h38,8'h39,8'h30,8'hBD,8'hBB,8'h08,8'h09,
    8'h51,8'h57,8'h45,8'h52,8'h54,8'h59,8'h55,8'h49,
    8'h4F,8'h50,8'hDB,8'hDD,8'h0D,8'hA2,8'h41,8'h53,
    8'h44,8'h46,8'h47,8'h48,8'h4A,8'h4B,8'h4C,8'hBA,
    8'hDE,8'hC0,8'hA0,8'hDC,8'h5A,8'h58,8'h43,8'h56,
    8'h42,8'h4E,8'h4D,8'hBC,8'hBE,8'hBF,8'hA1,8'h6A,
    8'hA4,8'h20,8'h14,8'h70,8'h71,8'h72,8'h73,8'h74,
    8'h75,8'h76,8'h77,8'h78,8'h79,8'h13,8'h91,8'h24,
    8'h26,8'h21,8'h6D,8'h25,8'h0C,8'h27,8'h6B,8'h23,
    8'h28,8'h22,8'h2D,8'h2E,8'h2C,8'h00,8'hE2,8'h7A,
    8'h7B,8'h0C,8'hEE,8'hF1,8'hEA,8'hF9,8'hF5,8'hF3,
    8'h00,8'h00,8'hFB,8'h2F,8'h7C,8'h7D,8'h7E,8'h7F,
    8'h80,8'h81,8'h82,8'h83,8'h84,8'h85,8'h86,8'hED,
    8'h00,8'hE9,8'h00,8'hC1,8'h00,8'h00,8'h87,8'h00,
    8'h00,8'h00,8'h00,8'hEB,8'h09,8'h00,8'hC2,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'hB1,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'hB0,8'h00,8'h00,8'h0D,8'hA3,8'h00,8'h00,
    8'hAD,8'hB6,8'hB3,8'h00,8'hB2,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'hAE,8'h00,
    8'hAF,8'h00,8'hB7,8'h00,8'h00,8'hBF,8'h00,8'h2A,
    8'hA5,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h90,8'h00,8'h24,
    8'h26,8'h21,8'h00,8'h25,8'h00,8'h27,8'h00,8'h23,
    8'h28,8'h22,8'h2D,8'h2E,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h5B,8'h5C,8'h5D,8'h00,8'h5F,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'hAA,8'hAB,8'hA8,
    8'hA9,8'hA7,8'hA6,8'hAC,8'hB4,8'hB5,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00
  };

endpackage

/* sv/kbeg_tick_store.sv */
// ----------------------------------------------------------------------------
// kbeg_tick_store: per-key last event tick memory
// One read and one write port, registered read, valid bits give zero reset.
// ----------------------------------------------------------------------------
module kbeg_tick_store #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr,
  output logic [kbeg_pkg::TICK_W-1:0] rd_data,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [kbeg_pkg::TICK_W-1:0] wr_data
);
  import kbeg_pkg::*;

  logic [TICK_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= valid[rd_addr] ? mem[rd_addr] : '0;
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

endmodule

/* sv/kbeg_event_engine.sv */
// ----------------------------------------------------------------------------
// kbeg_event_engine: per-bit sequencer, repeat compare and event output
// Walks the 32 key bits of one request, updates the tick store, emits events.
// ----------------------------------------------------------------------------
module kbeg_event_engine #(
  parameter int AW         = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  kbeg_pkg::cfg_t    cfg,
  input  logic              start,
  input  kbeg_pkg::in_t     item,
  input  logic [31:0]       was_bits,
  output logic              idle,
  output logic              out_valid,
  input  logic              out_ready,
  output kbeg_pkg::out_t    out_data,
  output logic              rd_en,
  output logic [AW-1:0]     rd_addr,
  input  logic [kbeg_pkg::TICK_W-1:0] rd_data,
  output logic              wr_en,
  output logic [AW-1:0]     wr_addr,
  output logic [kbeg_pkg::TICK_W-1:0] wr_data
);
  import kbeg_pkg::*;

  state_t            state;
  logic [BIT_W-1:0]  bit_cnt;
  logic [2:0]        blk;
  logic [31:0]       keys;
  logic [31:0]       was;
  logic [TICK_W-1:0] tick;
  logic              pend_valid;
  out_t              pend;

  logic [7:0]        sc;
  logic              cd, pd;
  logic [TICK_W-1:0] elapsed;
  logic              too_soon;
  logic              touch;
  logic [7:0]        code;
  logic              event_hit;
  logic              out_free;
  logic              stall;
  logic              push;
  logic              push_last;
  logic              last_bit;
  out_t              new_ev;
  out_t              push_ev;

  assign sc       = {blk, bit_cnt};
  assign cd       = keys[bit_cnt];
  assign pd       = was[bit_cnt];
  assign elapsed  = tick - rd_data;
  assign too_soon = elapsed < TICK_W'(cfg.repeat_interval_ms);
  assign touch    = (cd | pd) & ~(cd & pd & too_soon);
  assign code     = CODE_TABLE[sc];
  assign event_hit = touch & ~cfg.exclude[code];
  assign out_free = ~out_valid | out_ready;
  assign last_bit = bit_cnt == BIT_W'(BLOCK_BITS - 1);

  // hold the bit while the pending event cannot move to the output register
  assign stall = (state == S_EVAL) & event_hit & pend_valid & ~out_free;

  assign push      = ((state == S_EVAL) & event_hit & pend_valid & out_free) |
                     ((state == S_FLUSH) & pend_valid & out_free);
  assign push_last = state == S_FLUSH;

  always_comb begin
    new_ev.key_down     = cd;
    new_ev.key_code     = code;
    new_ev.message_word = {~cd, pd, 5'b0, sc > EXT_LIMIT, sc, 16'h0001};
    new_ev.last_event   = 1'b0;
    push_ev             = pend;
    push_ev.last_event  = push_last;
  end

  assign idle    = state == S_IDLE;
  assign rd_en   = state == S_READ;
  assign rd_addr = sc[AW-1:0];
  assign wr_en   = (state == S_EVAL) & touch & ~stall;
  assign wr_addr = sc[AW-1:0];
  assign wr_data = pd ? '0 : tick;

  always_ff @(posedge clk) begin
    if (start) begin
      blk  <= item.block_index;
      keys <= item.key_bits;
      was  <= was_bits;
      tick <= item.current_tick;
    end
    if (state == S_EVAL && event_hit && !stall) begin
      pend <= new_ev;
    end
    if (push) begin
      out_data <= push_ev;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      bit_cnt    <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          if (!stall) begin
            if (event_hit) begin
              pend_valid <= 1'b1;
            end
            bit_cnt <= bit_cnt + 1'b1;
            state   <= last_bit ? S_FLUSH : S_READ;
          end
        end
        S_FLUSH: begin
          if (!pend_valid) begin
            state <= S_IDLE;
          end else if (out_free) begin
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !pend_valid)
    else $error("pending event left over in idle");
  a_idle_bit_zero: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> bit_cnt == '0)
    else $error("bit counter not rewound at end of request");
  a_last_from_flush: assert property (@(posedge clk) disable iff (rst)
    push && push_last |=> out_valid && out_data.last_event)
    else $error("final event not marked");
`endif

endmodule

/* sv/key_bitmap_event_generator_unit.sv */
// ----------------------------------------------------------------------------
// key_bitmap_event_generator_unit: key bitmap to key event converter
// Compares 32-key bitmap blocks against the previous snapshot and emits
// press, release and repeat events with mapped codes and message words.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+------------------------------
//  in       | input     | in_valid / in_ready  | in_data  (block, bits, tick)
//  out      | output    | out_valid / out_ready| out_data (event)
//  cfg      | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  Sequence: for each key bit a request passes a tick store read state, then
//  a compare and write back state; a flush state follows the last bit, and
//  in_ready comes back in the idle state after it. A request whose block
//  index is out of range is taken and dropped, with no events.
//  Reset: rst, synchronous; clears registers, previous bitmap and tick valid
//  bits directly, with no clearing pass.
//  Stalls: a stalled output holds the key walk when an event is found while
//  both the pending event and out_data are full, and holds the flush until
//  out_data frees; in_ready returns while the final event still waits there.
//
module key_bitmap_event_generator_unit #(
  parameter int KEY_BLOCKS = kbeg_pkg::KEY_BLOCKS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  kbeg_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output kbeg_pkg::out_t  out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [2:0]      cfg_index,
  input  logic [63:0]     cfg_data
);
  import kbeg_pkg::*;

  localparam int DEPTH = KEY_BLOCKS * BLOCK_BITS;
  localparam int AW    = $clog2(DEPTH);
  localparam int BW    = (KEY_BLOCKS > 1) ? $clog2(KEY_BLOCKS) : 1;

  cfg_t              cfg;
  logic [31:0]       prev_keys [KEY_BLOCKS];
  logic              in_acc;
  logic              blk_ok;
  logic [BW-1:0]     blk_idx;
  logic [31:0]       was_bits;
  logic              eng_idle;

  logic              rd_en, wr_en;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic [TICK_W-1:0] rd_data, wr_data;

  // configuration writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.repeat_interval_ms <= INTERVAL_RST;
      cfg.exclude            <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_INTERVAL: cfg.repeat_interval_ms <= cfg_data[INTERVAL_W-1:0];
        REG_EXCL_0:   cfg.exclude[63:0]      <= cfg_data;
        REG_EXCL_1:   cfg.exclude[127:64]    <= cfg_data;
        REG_EXCL_2:   cfg.exclude[191:128]   <= cfg_data;
        REG_EXCL_3:   cfg.exclude[255:192]   <= cfg_data;
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  assign in_ready = eng_idle;
  assign in_acc   = in_valid & in_ready;
  assign blk_ok   = 32'(in_data.block_index) < KEY_BLOCKS;
  assign blk_idx  = BW'(in_data.block_index);
  assign was_bits = blk_ok ? prev_keys[blk_idx] : '0;

  // the engine latches the old snapshot at accept, so advance it right away
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < KEY_BLOCKS; i++) begin
        prev_keys[i] <= '0;
      end
    end else if (in_acc && blk_ok) begin
      prev_keys[blk_idx] <= in_data.key_bits;
    end
  end

  kbeg_event_engine #(
    .AW         (AW)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .start     (in_acc & blk_ok),
    .item      (in_data),
    .was_bits  (was_bits),
    .idle      (eng_idle),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  kbeg_tick_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ticks (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

endmodule

/* sim/tb_key_bitmap_event_generator_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_key_bitmap_event_generator_unit: self-checking bench for the key event unit
// Drives bitmap snapshot requests and register writes with random gaps and
// output stalls, predicts press, release and repeat events per key and checks
// every event field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_key_bitmap_event_generator_unit;
  import kbeg_pkg::*;

  localparam int          SETTLE_CYCLES = 80;        // one full key walk plus margin
  localparam int          LONG_HOLD     = 400;
  localparam int          LIMIT_CYCLES  = 3000000;
  localparam logic [2:0]  REG_SPARE     = 3'd7;      // index with no register behind it
  localparam logic [7:0]  ESC_CODE      = 8'h1B;
  localparam logic [7:0]  CTRL_CODE     = 8'hA2;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  in_valid = 1'b0;
  logic  in_ready;
  in_t   in_data = '0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  out_t  out_data;
  logic  cfg_valid = 1'b0;
  logic  cfg_ready;
  logic  [2:0]  cfg_index = '0;
  logic  [63:0] cfg_data = '0;

  // predictor state: last snapshot per block, event tick per scancode
  logic [31:0]  prev_bitmap [0:7];
  logic [31:0]  press_tick [0:255];
  logic [15:0]  repeat_ms;
  logic [255:0] excluded_codes;

  out_t        pending_events [$];
  int          error_count = 0;
  int          events_seen = 0;
  logic [31:0] now_ms = 32'd0;

  // idle controls shared between the tests and the handshake processes
  bit sender_gaps_on = 1'b1;
  bit ready_gaps_on  = 1'b1;
  bit hold_request   = 1'b0;

  key_bitmap_event_generator_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Mostly no gap, sometimes a short one, rarely a long one.
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 12) begin
      return 0;
    end else if (pick < 18) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(12, 48);
  endfunction

  // Work out the events of one accepted snapshot request, walking bit 0 to 31.
  task automatic predict_key_events(input in_t req);
    out_t        batch [$];
    out_t        ev;
    logic [31:0] was;
    logic [31:0] elapsed;
    logic [7:0]  sc;
    logic [7:0]  code;
    logic        now_dn;
    logic        was_dn;
    was = prev_bitmap[req.block_index];
    for (int b = 0; b < 32; b++) begin
      sc = {req.block_index, b[4:0]};
      now_dn = req.key_bits[b];
      was_dn = was[b];
      if (!now_dn && !was_dn) continue;
      elapsed = req.current_tick - press_tick[sc];
      // held key: repeat only once the interval has run out
      if (now_dn && was_dn && elapsed < {16'd0, repeat_ms}) continue;
      press_tick[sc] = was_dn ? 32'd0 : req.current_tick;
      code = CODE_TABLE[sc];
      // excluded codes still move the tick store, only the event is dropped
      if (excluded_codes[code]) continue;
      ev.key_down     = now_dn;
      ev.key_code     = code;
      ev.message_word = {~now_dn, was_dn, 5'd0, (sc > EXT_LIMIT), sc, 16'd1};
      ev.last_event   = 1'b0;
      batch.push_back(ev);
    end
    if (batch.size() > 0) begin
      batch[batch.size() - 1].last_event = 1'b1;
    end
    foreach (batch[i]) begin
      pending_events.push_back(batch[i]);
    end
    prev_bitmap[req.block_index] = req.key_bits;
  endtask

  // Offer one snapshot request; called and returns at a falling edge.
  task automatic send_snapshot(input logic [2:0] blk, input logic [31:0] bits,
                               input logic [31:0] tick);
    in_t req;
    int  gap;
    req.block_index  = blk;
    req.key_bits     = bits;
    req.current_tick = tick;
    in_data  <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_ready !== 1'b1);
    predict_key_events(req);
    @(negedge clk);
    gap = sender_gaps_on ? idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Write one register; only called while the unit is quiet.
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      REG_INTERVAL: repeat_ms = value[15:0];
      REG_EXCL_0:   excluded_codes[63:0]    = value;
      REG_EXCL_1:   excluded_codes[127:64]  = value;
      REG_EXCL_2:   excluded_codes[191:128] = value;
      REG_EXCL_3:   excluded_codes[255:192] = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_masks(input logic [63:0] m0, input logic [63:0] m1,
                             input logic [63:0] m2, input logic [63:0] m3);
    write_reg(REG_EXCL_0, m0);
    write_reg(REG_EXCL_1, m1);
    write_reg(REG_EXCL_2, m2);
    write_reg(REG_EXCL_3, m3);
  endtask

  // Drop valid and hold until every predicted event has come out.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_events.size() != 0);
  endtask

  // A request may produce no event and still be walking its keys: let it finish.
  task automatic wait_quiet();
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("MISMATCH event %0d %s: expected %h got %h", events_seen, what, want, got);
    error_count++;
  endtask

  // Output side: random stalls, plus a long hold when a test asks for one.
  initial begin
    int hold_left;
    int run_left;
    int gap_left;
    logic nxt;
    hold_left = 0;
    run_left  = 0;
    gap_left  = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left    = LONG_HOLD;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt = 1'b0;
      end else if (!ready_gaps_on) begin
        nxt = 1'b1;
      end else if (run_left > 0) begin
        run_left--;
        nxt = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        nxt = 1'b0;
      end else begin
        run_left = $urandom_range(1, 12);
        gap_left = idle_len();
        nxt = 1'b1;
      end
      out_ready <= nxt;
    end
  end

  // Check each accepted event against the oldest prediction.
  always @(posedge clk) begin : check_events
    out_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_events.size() == 0) begin
        report_mismatch("unexpected event, message_word", 32'd0, out_data.message_word);
      end else begin
        want = pending_events.pop_front();
        if (out_data.key_down !== want.key_down)
          report_mismatch("key_down", 32'(want.key_down), 32'(out_data.key_down));
        if (out_data.key_code !== want.key_code)
          report_mismatch("key_code", 32'(want.key_code), 32'(out_data.key_code));
        if (out_data.message_word !== want.message_word)
          report_mismatch("message_word", want.message_word, out_data.message_word);
        if (out_data.last_event !== want.last_event)
          report_mismatch("last_event", 32'(want.last_event), 32'(out_data.last_event));
      end
      events_seen++;
    end
  end

  // Watchdog: count cycles and give up at the limit.
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("key_bitmap_event_generator_unit test failed");
    $finish;
  end

  // Press, hold below and at the interval, repeat on a cleared tick, release.
  task automatic test_press_release();
    send_snapshot(3'd0, 32'h0000_0003, 32'd1000);
    send_snapshot(3'd0, 32'h0000_0003, 32'd1200);  // held, too early: no event
    send_snapshot(3'd0, 32'h0000_0001, 32'd1300);
    send_snapshot(3'd0, 32'h0000_0001, 32'd1500);  // exactly one interval
    send_snapshot(3'd0, 32'h0000_0001, 32'd1501);  // tick was cleared, repeats again
    send_snapshot(3'd0, 32'h0000_0000, 32'd1502);
  endtask

  // Full blocks, tick wrap, and the scancode boundary of the extended bit.
  task automatic test_block_extremes();
    send_snapshot(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFF0);
    send_snapshot(3'd7, 32'hFFFF_FFFF, 32'h0000_01E3);  // one ms short across the wrap
    send_snapshot(3'd7, 32'hFFFF_FFFF, 32'h0000_01E4);
    send_snapshot(3'd7, 32'h0000_0000, 32'h0000_0000);
    send_snapshot(3'd3, 32'h8000_0000, 32'd42);
    send_snapshot(3'd4, 32'h0000_0001, 32'd43);
    send_snapshot(3'd3, 32'h0000_0000, 32'd44);
    send_snapshot(3'd4, 32'h0000_0000, 32'd45);
    send_snapshot(3'd5, 32'hA5A5_5A5A, $urandom);
    send_snapshot(3'd5, 32'h5A5A_A5A5, $urandom);
  endtask

  // Interval extremes, full and partial exclusion, spare register index.
  task automatic test_register_extremes();
    wait_quiet();
    write_reg(REG_INTERVAL, 64'd0);
    send_snapshot(3'd2, 32'h0000_00FF, 32'd10);
    send_snapshot(3'd2, 32'h0000_00FF, 32'd10);    // zero interval: repeat at once
    wait_quiet();
    write_reg(REG_INTERVAL, {$urandom, 16'($urandom_range(0, 65535)), 16'hFFFF});
    send_snapshot(3'd2, 32'h0000_00FF, 32'd65534);
    send_snapshot(3'd2, 32'h0000_00FF, 32'd65535);
    wait_quiet();
    write_masks('1, '1, '1, '1);
    send_snapshot(3'd1, 32'hFFFF_FFFF, 32'd70000); // all dropped, ticks still stored
    wait_quiet();
    write_masks('0, '0, '0, '0);
    write_reg(REG_SPARE, {$urandom, $urandom});
    send_snapshot(3'd1, 32'hFFFF_FFFF, 32'd70100);
    wait_quiet();
    write_reg(REG_INTERVAL, 64'd100);
    send_snapshot(3'd1, 32'hFFFF_FFFF, 32'd70200);
    wait_quiet();
    write_masks(64'd1 << ESC_CODE[5:0], {$urandom, $urandom},
                64'd1 << CTRL_CODE[5:0], {$urandom, $urandom});
    send_snapshot(3'd0, 32'hFFFF_FFFF, 32'd80000);
    send_snapshot(3'd0, 32'h0000_0000, 32'd80001);
    wait_quiet();
    write_masks('0, '0, '0, '0);
    write_reg(REG_INTERVAL, 64'd500);
  endtask

  // Hold the output for a long stretch while requests keep coming.
  task automatic test_output_backpressure();
    wait_quiet();
    sender_gaps_on = 1'b0;
    hold_request   = 1'b1;
    for (int i = 0; i < 12; i++) begin
      now_ms += $urandom_range(100, 900);
      send_snapshot(3'd6, (i % 2 == 0) ? 32'hFFFF_FFFF : $urandom, now_ms);
    end
    sender_gaps_on = 1'b1;
  endtask

  // Pause the sender until every event is out, then resume.
  task automatic test_drain_pause();
    for (int i = 0; i < 6; i++) begin
      if (i == 3) hold_until_drained();
      now_ms += $urandom_range(0, 700);
      send_snapshot(i[2:0], $urandom, now_ms);
    end
  endtask

  // Random phases: mostly key toggles on a moving tick, some raw noise.
  task automatic test_random_typing();
    logic [2:0]  blk;
    logic [31:0] bits;
    logic [31:0] toggle;
    logic [31:0] tick;
    for (int phase = 0; phase < 6; phase++) begin
      wait_quiet();
      case (phase)
        0: write_reg(REG_INTERVAL, 64'($urandom_range(200, 800)));
        1: write_reg(REG_INTERVAL, 64'd0);
        2: write_reg(REG_INTERVAL, 64'd65535);
        3: write_reg(REG_INTERVAL, 64'd1);
        default: write_reg(REG_INTERVAL, 64'($urandom_range(0, 1500)));
      endcase
      if (phase == 4) begin
        write_masks('1, '0, {$urandom, $urandom}, '0);
      end else if (phase % 2 == 1) begin
        write_masks({$urandom, $urandom} & {$urandom, $urandom},
                    {$urandom, $urandom} & {$urandom, $urandom},
                    {$urandom, $urandom} & {$urandom, $urandom},
                    {$urandom, $urandom} & {$urandom, $urandom});
      end else begin
        write_masks('0, '0, '0, '0);
      end
      sender_gaps_on = (phase != 2);
      ready_gaps_on  = (phase != 3);
      for (int i = 0; i < 23; i++) begin
        if (i == 11 && phase == 5) hold_until_drained();
        blk = 3'($urandom_range(0, 7));
        if ($urandom_range(0, 4) == 0) begin
          bits = $urandom;
          tick = $urandom;
        end else begin
          case ($urandom_range(0, 4))
            0: toggle = 32'd0;                          // keep holding
            1: toggle = $urandom & $urandom & $urandom;
            2: toggle = 32'd1 << $urandom_range(0, 31);
            3: toggle = prev_bitmap[blk];               // let everything go
            default: toggle = $urandom & $urandom;
          endcase
          bits = prev_bitmap[blk] ^ toggle;
          now_ms += $urandom_range(0, 1200);
          tick = now_ms;
        end
        send_snapshot(blk, bits, tick);
      end
    end
    sender_gaps_on = 1'b1;
    ready_gaps_on  = 1'b1;
  endtask

  initial begin
    repeat_ms      = INTERVAL_RST;
    excluded_codes = '0;
    foreach (prev_bitmap[i]) prev_bitmap[i] = '0;
    foreach (press_tick[i]) press_tick[i] = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_press_release();
    test_block_extremes();
    test_register_extremes();
    test_output_backpressure();
    test_drain_pause();
    test_random_typing();

    // drain, then give any stray event time to show up
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("key_bitmap_event_generator_unit test passed");
    end else begin
      $display("key_bitmap_event_generator_unit test failed");
    end
    $finish;
  end

endmodule
